FILE: hdl/psrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrr_pkg
// Shared types and constants of the pad script replay recorder.
// ----------------------------------------------------------------------------
package psrr_pkg;

    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 160;
    localparam int KIND_W      = 2;
    localparam int REG_IDX_W   = 1;
    localparam int ENTRY_W     = 97;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    localparam logic [REG_IDX_W-1:0] REG_REPLAY_ENABLE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_RECORD_ENABLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SETTLE,
        S_FRAME_OUT,
        S_FLUSH_OUT
    } t_state;

    typedef struct packed {
        logic [31:0]        frame;
        logic [31:0]        entry_first;
        logic [31:0]        entry_last;
        logic [15:0]        entry_buttons;
        logic               entry_has_stick;
        logic signed [7:0]  entry_x;
        logic signed [7:0]  entry_y;
        logic [15:0]        live_buttons;
        logic signed [7:0]  live_x;
        logic signed [7:0]  live_y;
    } t_item;

    typedef struct packed {
        logic capture;
        logic store;
        logic scan_read;
        logic frame_out;
        logic flush_out;
    } t_cmd;

    typedef struct packed {
        logic replay_en;
        logic count_zero;
        logic count_full;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/psrr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrr_ctrl
// Sequencer: accepts items, walks the entry table on replayed frames and
// hands results to the output register.
// ----------------------------------------------------------------------------
module psrr_ctrl
    import psrr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic [KIND_W-1:0]   i_kind,
    output logic                o_s_tready,
    input  t_status             i_status,
    output t_cmd                o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_accept = i_s_tvalid && (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_kind)
                        KIND_LOAD: begin
                            o_cmd.store = !i_status.count_full;
                        end
                        KIND_FRAME: begin
                            if (i_status.replay_en && !i_status.count_zero) begin
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_FRAME_OUT;
                            end
                        end
                        KIND_FINISH: begin
                            n_state = S_FLUSH_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_read = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                // last read word is folded in during this cycle
                n_state = S_FRAME_OUT;
            end
            S_FRAME_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.frame_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FLUSH_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.flush_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_scan_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_status.count_zero)
        else $error("table scan with empty table");

    a_result_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.frame_out || o_cmd.flush_out) |-> i_status.out_free)
        else $error("result loaded into occupied output register");

    a_settle_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETTLE) |-> $past(r_state == S_SCAN))
        else $error("settle cycle without preceding scan");

endmodule

FILE: hdl/psrr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrr_datapath
// Entry table memory, match accumulation, press counter, run tracker and
// the output register.
// ----------------------------------------------------------------------------
module psrr_datapath
    import psrr_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [REG_IDX_W-1:0]    i_cfg_index,
    input  logic                    i_cfg_wdata,
    input  t_item                   i_item,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_m_tready,
    output logic                    o_m_tvalid,
    output logic [15:0]             o_pad_buttons,
    output logic signed [7:0]       o_pad_x,
    output logic signed [7:0]       o_pad_y,
    output logic [31:0]             o_press_total,
    output logic                    o_run_valid,
    output logic [31:0]             o_run_start,
    output logic [31:0]             o_run_length,
    output logic [15:0]             o_run_buttons,
    output logic signed [7:0]       o_run_x,
    output logic signed [7:0]       o_run_y
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // entry table: first, last, buttons, has_stick, x, y
    logic [ENTRY_W-1:0]     r_mem [ENTRIES];
    logic [ENTRY_W-1:0]     r_rd_data;
    logic                   r_rd_valid;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_addr;
    logic                   r_replay_en;
    logic                   r_record_en;
    t_item                  r_item;
    logic                   r_item_replay;

    logic [15:0]            r_acc_btn;
    logic signed [7:0]      r_acc_x;
    logic signed [7:0]      r_acc_y;

    logic [31:0]            r_press;
    logic                   r_run_open;
    logic [31:0]            r_run_start;
    logic [31:0]            r_run_state;
    logic [31:0]            r_last_frame;
    logic                   r_frame_seen;
    logic                   r_out_valid;

    logic [31:0]            w_rd_first;
    logic [31:0]            w_rd_last;
    logic [15:0]            w_rd_btn;
    logic                   w_rd_has;
    logic signed [7:0]      w_rd_x;
    logic signed [7:0]      w_rd_y;
    logic                   w_match;

    logic [15:0]            w_btn;
    logic signed [7:0]      w_x;
    logic signed [7:0]      w_y;
    logic [31:0]            w_state;
    logic [31:0]            w_press_next;
    logic [31:0]            w_end;
    logic                   w_span_ok;
    logic                   w_frame_close;
    logic                   w_flush_close;
    logic                   w_close;

    // status toward the sequencer
    assign o_status.replay_en  = r_replay_en;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.count_full = (r_count == CNT_W'(ENTRIES));
    assign o_status.scan_last  = (r_addr == (r_count - CNT_W'(1)));
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_item.entry_first, i_item.entry_last,
                                          i_item.entry_buttons, i_item.entry_has_stick,
                                          i_item.entry_x, i_item.entry_y};
        end
        if (i_cmd.scan_read) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    assign {w_rd_first, w_rd_last, w_rd_btn, w_rd_has, w_rd_x, w_rd_y} = r_rd_data;
    assign w_match = (r_item.frame >= w_rd_first) && (r_item.frame <= w_rd_last);

    // result of the current frame or finish item
    always_comb begin
        if (r_item_replay) begin
            w_btn = r_acc_btn;
            w_x   = r_acc_x;
            w_y   = r_acc_y;
        end else begin
            w_btn = r_item.live_buttons;
            w_x   = r_item.live_x;
            w_y   = r_item.live_y;
        end
        w_state      = {w_btn, w_x, w_y};
        w_press_next = (r_item_replay && (w_btn != '0)) ? (r_press + 32'd1) : r_press;
        w_end        = i_cmd.flush_out ? (r_last_frame + 32'd1) : r_item.frame;
        w_span_ok    = r_run_open && (w_end > r_run_start);
        w_frame_close = r_record_en && (w_state != r_run_state) && w_span_ok;
        w_flush_close = r_record_en && r_frame_seen && w_span_ok;
        w_close      = i_cmd.flush_out ? w_flush_close : w_frame_close;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_replay_en  <= 1'b0;
            r_record_en  <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_press      <= '0;
            r_run_open   <= 1'b0;
            r_run_start  <= '0;
            r_run_state  <= '0;
            r_last_frame <= '0;
            r_frame_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REPLAY_ENABLE: r_replay_en <= i_cfg_wdata;
                    REG_RECORD_ENABLE: r_record_en <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.store) begin
                r_count <= r_count + CNT_W'(1);
            end
            r_rd_valid <= i_cmd.scan_read;
            if (i_cmd.frame_out) begin
                r_press      <= w_press_next;
                r_last_frame <= r_item.frame;
                r_frame_seen <= 1'b1;
                if (r_record_en && (!r_run_open || (w_state != r_run_state))) begin
                    r_run_open  <= 1'b1;
                    r_run_start <= r_item.frame;
                    r_run_state <= w_state;
                end
            end else if (i_cmd.flush_out) begin
                if (r_record_en && r_frame_seen) begin
                    r_run_open <= 1'b0;
                end
            end
            if (i_cmd.frame_out || i_cmd.flush_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, scan pointer and match accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item        <= i_item;
            r_item_replay <= r_replay_en;
            r_addr        <= '0;
            r_acc_btn     <= '0;
            r_acc_x       <= '0;
            r_acc_y       <= '0;
        end else begin
            if (i_cmd.scan_read) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (r_rd_valid && w_match) begin
                r_acc_btn <= r_acc_btn | w_rd_btn;
                if (w_rd_has) begin
                    r_acc_x <= w_rd_x;
                    r_acc_y <= w_rd_y;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_out || i_cmd.flush_out) begin
            o_press_total <= i_cmd.frame_out ? w_press_next : r_press;
            o_run_valid   <= w_close;
            o_run_start   <= w_close ? r_run_start : '0;
            o_run_length  <= w_close ? (w_end - r_run_start) : '0;
            o_run_buttons <= w_close ? r_run_state[31:16] : '0;
            o_run_x       <= w_close ? r_run_state[15:8] : '0;
            o_run_y       <= w_close ? r_run_state[7:0] : '0;
            if (i_cmd.frame_out) begin
                o_pad_buttons <= w_btn;
                o_pad_x       <= w_x;
                o_pad_y       <= w_y;
            end else begin
                o_pad_buttons <= '0;
                o_pad_x       <= '0;
                o_pad_y       <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond table depth");

    a_read_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_read |-> (r_addr < r_count))
        else $error("scan reads an unwritten entry");

    a_no_store_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> !o_status.count_full)
        else $error("store into full table");

endmodule

FILE: hdl/pad_script_replay_recorder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_script_replay_recorder_unit
// Controller-input replay table with run-length recording of the pad state.
// ----------------------------------------------------------------------------
// A load item leaves the block idle and ready for the next item. A frame item
// with replay enabled walks the stored entries through the single read port of
// the entry table, one entry per cycle, then passes a settle state and waits for
// a free output register before the block is ready for the next item; a frame
// without replay or with an empty table, and a finish item, only wait for a free
// output register. One result is held in an output register, so a new item is
// taken while that result waits, and a further result waits for the slot to
// clear. The entry table needs no clearing after reset. Entries beyond
// ENTRIES are dropped.
module pad_script_replay_recorder_unit
    import psrr_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [REG_IDX_W-1:0]        i_cfg_index,
    input  logic                        i_cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // frame, entry_first, entry_last, entry_buttons, entry_has_stick,
    // entry_x, entry_y, live_buttons, live_x, live_y, zero pad
    input  logic [IN_TDATA_W-1:0]       s_tdata,
    // kind
    input  logic [KIND_W-1:0]           s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pad_buttons, pad_x, pad_y, press_total, run_start, run_length,
    // run_buttons, run_x, run_y
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // run_valid
    output logic                        m_tuser
);

    t_item              w_item;
    t_cmd               w_cmd;
    t_status            w_status;
    logic [15:0]        w_pad_buttons;
    logic signed [7:0]  w_pad_x;
    logic signed [7:0]  w_pad_y;
    logic [31:0]        w_press_total;
    logic [31:0]        w_run_start;
    logic [31:0]        w_run_length;
    logic [15:0]        w_run_buttons;
    logic signed [7:0]  w_run_x;
    logic signed [7:0]  w_run_y;

    assign w_item.frame           = s_tdata[31:0];
    assign w_item.entry_first     = s_tdata[63:32];
    assign w_item.entry_last      = s_tdata[95:64];
    assign w_item.entry_buttons   = s_tdata[111:96];
    assign w_item.entry_has_stick = s_tdata[112];
    assign w_item.entry_x         = s_tdata[120:113];
    assign w_item.entry_y         = s_tdata[128:121];
    assign w_item.live_buttons    = s_tdata[144:129];
    assign w_item.live_x          = s_tdata[152:145];
    assign w_item.live_y          = s_tdata[160:153];

    psrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_kind     (s_tuser),
        .o_s_tready (s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    psrr_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item        (w_item),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_m_tready    (m_tready),
        .o_m_tvalid    (m_tvalid),
        .o_pad_buttons (w_pad_buttons),
        .o_pad_x       (w_pad_x),
        .o_pad_y       (w_pad_y),
        .o_press_total (w_press_total),
        .o_run_valid   (m_tuser),
        .o_run_start   (w_run_start),
        .o_run_length  (w_run_length),
        .o_run_buttons (w_run_buttons),
        .o_run_x       (w_run_x),
        .o_run_y       (w_run_y)
    );

    assign m_tdata = {w_run_y, w_run_x, w_run_buttons, w_run_length, w_run_start,
                      w_press_total, w_pad_y, w_pad_x, w_pad_buttons};

endmodule
